FILE: design/mm_pkg.sv
// shared types, codes and defaults of the matrix multiply block
`default_nettype none

package mm_pkg;

	// default values of the top level parameters
	localparam int MAX_DIM_DEF    = 8;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// fixed field widths
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 4;
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// input operation codes
	localparam logic [1:0] OP_WR_A = 2'd0;
	localparam logic [1:0] OP_WR_B = 2'd1;
	localparam logic [1:0] OP_RUN  = 2'd2;

	// register indexes on the configuration port
	localparam logic [1:0] REG_ROWS_A    = 2'd0;
	localparam logic [1:0] REG_INNER_DIM = 2'd1;
	localparam logic [1:0] REG_COLS_B    = 2'd2;

	// command kinds passed from front to back
	typedef enum logic [1:0] {
		CMD_WR_A = 2'd0,
		CMD_WR_B = 2'd1,
		CMD_RUN  = 2'd2
	} cmd_t;

	// matrix sizes as written on the configuration port
	typedef struct packed {
		logic [CFG_W-1:0] rows_a;
		logic [CFG_W-1:0] inner_dim;
		logic [CFG_W-1:0] cols_b;
	} dims_t;

	// command queue fill status
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

FILE: design/mm_front.sv
// front end: accepts items, classifies them and hands commands to the queue
`default_nettype none

module mm_front import mm_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int ADDR_W     = 6
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [1:0]              operation,
	input  wire logic [IDX_W-1:0]        row,
	input  wire logic [IDX_W-1:0]        col,
	input  wire logic [DATA_WIDTH-1:0]   value,
	input  wire q_status_t               q_status,
	output logic                         busy,
	output logic                         push,
	output cmd_t                         push_cmd,
	output logic [ADDR_W-1:0]            push_addr,
	output logic [DATA_WIDTH-1:0]        push_data
);

	logic                  slot_valid_q;
	cmd_t                  slot_cmd_q;
	logic [ADDR_W-1:0]     slot_addr_q;
	logic [DATA_WIDTH-1:0] slot_data_q;

	logic                  accept;
	logic                  in_range;
	logic                  keep;
	cmd_t                  cmd;
	logic [ADDR_W-1:0]     addr;

	// slot drains into the queue whenever there is room
	assign push   = slot_valid_q & ~q_status.full;
	assign busy   = slot_valid_q & q_status.full;
	assign accept = start & ~busy;

	// classify the incoming beat
	assign in_range = ({1'b0, row} < (IDX_W+1)'(MAX_DIM)) &&
	                  ({1'b0, col} < (IDX_W+1)'(MAX_DIM));
	assign addr     = ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);

	always_comb begin
		keep = 1'b0;
		cmd  = CMD_RUN;
		unique case (operation)
			OP_WR_A: begin
				keep = in_range;
				cmd  = CMD_WR_A;
			end
			OP_WR_B: begin
				keep = in_range;
				cmd  = CMD_WR_B;
			end
			OP_RUN: begin
				keep = 1'b1;
				cmd  = CMD_RUN;
			end
			default: begin
				keep = 1'b0;
				cmd  = CMD_RUN;
			end
		endcase
	end

	// one-entry holding slot, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= 1'b0;
		end else if (accept) begin
			slot_valid_q <= keep;
		end else if (push) begin
			slot_valid_q <= 1'b0;
		end
	end

	// holding slot payload
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_cmd_q  <= cmd;
			slot_addr_q <= addr;
			slot_data_q <= value;
		end
	end

	assign push_cmd  = slot_cmd_q;
	assign push_addr = slot_addr_q;
	assign push_data = slot_data_q;

endmodule

`default_nettype wire

FILE: design/mm_queue.sv
// two-entry command queue between front and back
`default_nettype none

module mm_queue import mm_pkg::*; #(
	parameter int W = 40
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	input  wire logic         pop,
	output logic     [W-1:0]  pop_data,
	output q_status_t         status
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign pop_data     = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

FILE: design/mm_back.sv
// back end: element stores, MAC sequencer, rounding and saturation
`default_nettype none

module mm_back import mm_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int ADDR_W     = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dims_t                 dims,
	input  wire q_status_t             q_status,
	input  wire cmd_t                  q_cmd,
	input  wire logic [ADDR_W-1:0]     q_addr,
	input  wire logic [DATA_WIDTH-1:0] q_data,
	output logic                       pop,
	output logic                       out_valid,
	output logic [IDX_W-1:0]           out_row,
	output logic [IDX_W-1:0]           out_col,
	output logic [DATA_WIDTH-1:0]      out_value,
	output logic                       saturated,
	output logic                       last
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
	localparam int RND_W  = ACC_W + 1;
	localparam int UP_W   = RND_W - DATA_WIDTH + 1;
	localparam logic [RND_W-1:0] HALF = (RND_W'(1) << FRAC_BITS) >> 1;
	localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	// element stores
	logic [DATA_WIDTH-1:0] a_mem [DEPTH];
	logic [DATA_WIDTH-1:0] b_mem [DEPTH];

	state_t           state_q;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic [IDX_W-1:0] nr_m1_q, nk_m1_q, nc_m1_q;

	logic              issue;
	logic              last_i, last_j, last_k;
	logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;

	// stage 1: read data and tags
	logic [DATA_WIDTH-1:0] rd_a_s1, rd_b_s1;
	logic                  v_s1, first_s1, lastk_s1, lastel_s1;
	logic [IDX_W-1:0]      i_s1, j_s1;

	// stage 2: product
	logic signed [PROD_W-1:0] prod_s2;
	logic                     v_s2, first_s2, lastk_s2, lastel_s2;
	logic [IDX_W-1:0]         i_s2, j_s2;

	// stage 3: accumulator, done tags
	logic signed [ACC_W-1:0] acc_q;
	logic                    done_s3, lastel_s3;
	logic [IDX_W-1:0]        i_s3, j_s3;

	// stage 4: result
	logic                  v_s4, sat_s4, last_s4;
	logic [IDX_W-1:0]      row_s4, col_s4;
	logic [DATA_WIDTH-1:0] value_s4;

	logic signed [ACC_W-1:0] prod_ext;
	logic signed [RND_W-1:0] rnd_sum;
	logic signed [RND_W-1:0] shifted;
	logic [UP_W-1:0]         upper;
	logic                    fits;

	// size register to last index, zero read as one, clipped to MAX_DIM
	function automatic logic [IDX_W-1:0] eff_m1(input logic [CFG_W-1:0] r);
		logic [IDX_W-1:0] res;
		if (r == '0) begin
			res = '0;
		end else if (r > CFG_W'(MAX_DIM)) begin
			res = IDX_W'(MAX_DIM - 1);
		end else begin
			res = IDX_W'(r - CFG_W'(1));
		end
		return res;
	endfunction

	assign pop   = (state_q == ST_IDLE) && !q_status.empty;
	assign issue = (state_q == ST_RUN);

	assign last_i = (i_q == nr_m1_q);
	assign last_j = (j_q == nc_m1_q);
	assign last_k = (k_q == nk_m1_q);

	assign rd_addr_a = ADDR_W'(i_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q);
	assign rd_addr_b = ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q);

	// sequencer: takes commands, steps i, j, k one MAC per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			nr_m1_q <= '0;
			nk_m1_q <= '0;
			nc_m1_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop && q_cmd == CMD_RUN) begin
						state_q <= ST_RUN;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						nr_m1_q <= eff_m1(dims.rows_a);
						nk_m1_q <= eff_m1(dims.inner_dim);
						nc_m1_q <= eff_m1(dims.cols_b);
					end
				end
				ST_RUN: begin
					if (last_k) begin
						k_q <= '0;
						if (last_j) begin
							j_q <= '0;
							if (last_i) begin
								state_q <= ST_IDLE;
							end else begin
								i_q <= i_q + IDX_W'(1);
							end
						end else begin
							j_q <= j_q + IDX_W'(1);
						end
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
			endcase
		end
	end

	// store writes
	always_ff @(posedge clk) begin
		if (pop && q_cmd == CMD_WR_A) begin
			a_mem[q_addr] <= q_data;
		end
		if (pop && q_cmd == CMD_WR_B) begin
			b_mem[q_addr] <= q_data;
		end
	end

	// store reads, registered
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_a_s1 <= a_mem[rd_addr_a];
			rd_b_s1 <= b_mem[rd_addr_b];
		end
	end

	// pipeline valid and done flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_s3 <= 1'b0;
			v_s4    <= 1'b0;
		end else begin
			v_s1    <= issue;
			v_s2    <= v_s1;
			done_s3 <= v_s2 & lastk_s2;
			v_s4    <= done_s3;
		end
	end

	// tags travel with the data
	always_ff @(posedge clk) begin
		first_s1  <= (k_q == '0);
		lastk_s1  <= last_k;
		lastel_s1 <= last_i & last_j;
		i_s1      <= i_q;
		j_s1      <= j_q;
		first_s2  <= first_s1;
		lastk_s2  <= lastk_s1;
		lastel_s2 <= lastel_s1;
		i_s2      <= i_s1;
		j_s2      <= j_s1;
		lastel_s3 <= lastel_s2;
		i_s3      <= i_s2;
		j_s3      <= j_s2;
	end

	// multiply
	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= $signed(rd_a_s1) * $signed(rd_b_s1);
		end
	end

	// accumulate, restart on the first term of each dot product
	assign prod_ext = {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= first_s2 ? prod_ext : acc_q + prod_ext;
		end
	end

	// round half up, drop fraction bits, check range
	assign rnd_sum = $signed({acc_q[ACC_W-1], acc_q}) + $signed(HALF);
	assign shifted = rnd_sum >>> FRAC_BITS;
	assign upper   = shifted[RND_W-1:DATA_WIDTH-1];
	assign fits    = (&upper) | ~(|upper);

	// result register
	always_ff @(posedge clk) begin
		if (done_s3) begin
			row_s4   <= i_s3;
			col_s4   <= j_s3;
			last_s4  <= lastel_s3;
			sat_s4   <= ~fits;
			value_s4 <= fits ? shifted[DATA_WIDTH-1:0] :
			            (shifted[RND_W-1] ? MINV : MAXV);
		end
	end

	assign out_valid = v_s4;
	assign out_row   = row_s4;
	assign out_col   = col_s4;
	assign out_value = value_s4;
	assign saturated = v_s4 & sat_s4;
	assign last      = v_s4 & last_s4;

endmodule

`default_nettype wire

FILE: design/matrix_multiply.sv
// top level of the matrix multiply block: config registers, front, queue, back
`default_nettype none

// Fixed-point matrix multiply P = A * B. Items enter on start while busy is
// low: operation 0 and 1 write one element of A or B (an index at or above
// MAX_DIM is dropped), operation 2 computes the product. The front holds one
// beat and a two-entry queue follows it, so items are taken one per cycle
// until both are full. The back takes queued items one at a time and, per
// compute, issues rows_a*cols_b*inner_dim MACs, one MAC per cycle on the
// single multiplier, taking no new item meanwhile; products pass the read,
// multiply, accumulate and result registers. Results come out in row-major
// order, each on the result ports for one cycle under out_valid; they cannot
// be held off, so the receiver must take every beat. Sizes are read at the
// start of each compute and must not change while results are pending.
module matrix_multiply import mm_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_AW-1:0]     paddr,
	input  wire logic [APB_DW-1:0]     pwdata,
	output logic      [APB_DW-1:0]     prdata,
	output logic                       pready,
	// command side
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            operation,
	input  wire logic [IDX_W-1:0]      row,
	input  wire logic [IDX_W-1:0]      col,
	input  wire logic [DATA_WIDTH-1:0] value,
	// result side
	output logic                       out_valid,
	output logic [IDX_W-1:0]           out_row,
	output logic [IDX_W-1:0]           out_col,
	output logic [DATA_WIDTH-1:0]      out_value,
	output logic                       saturated,
	output logic                       last
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMD_W  = $bits(cmd_t);
	localparam int Q_W    = CMD_W + ADDR_W + DATA_WIDTH;
	localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	dims_t                 dims_q;
	logic                  cfg_wr;

	q_status_t             q_status;
	logic                  q_push;
	cmd_t                  push_cmd;
	logic [ADDR_W-1:0]     push_addr;
	logic [DATA_WIDTH-1:0] push_data;
	logic                  q_pop;
	logic [Q_W-1:0]        q_head;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q.rows_a    <= CFG_W'(8);
			dims_q.inner_dim <= CFG_W'(8);
			dims_q.cols_b    <= CFG_W'(8);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_ROWS_A:    dims_q.rows_a    <= pwdata[CFG_W-1:0];
				REG_INNER_DIM: dims_q.inner_dim <= pwdata[CFG_W-1:0];
				REG_COLS_B:    dims_q.cols_b    <= pwdata[CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[3:2])
			REG_ROWS_A:    prdata = APB_DW'(dims_q.rows_a);
			REG_INNER_DIM: prdata = APB_DW'(dims_q.inner_dim);
			REG_COLS_B:    prdata = APB_DW'(dims_q.cols_b);
			default:       prdata = '0;
		endcase
	end

	mm_front #(
		.MAX_DIM    (MAX_DIM),
		.DATA_WIDTH (DATA_WIDTH),
		.ADDR_W     (ADDR_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.row       (row),
		.col       (col),
		.value     (value),
		.q_status  (q_status),
		.busy      (busy),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.push_addr (push_addr),
		.push_data (push_data)
	);

	mm_queue #(
		.W (Q_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_cmd, push_addr, push_data}),
		.pop       (q_pop),
		.pop_data  (q_head),
		.status    (q_status)
	);

	mm_back #(
		.MAX_DIM    (MAX_DIM),
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS),
		.ADDR_W     (ADDR_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dims      (dims_q),
		.q_status  (q_status),
		.q_cmd     (cmd_t'(q_head[Q_W-1 -: CMD_W])),
		.q_addr    (q_head[DATA_WIDTH +: ADDR_W]),
		.q_data    (q_head[DATA_WIDTH-1:0]),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.saturated (saturated),
		.last      (last)
	);

	// queue never takes a beat when full, never gives one when empty
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && !q_pop |-> !q_status.full)
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("command queue underflow");

	// flags only on a result beat
	a_flags_strobed: assert property (@(posedge clk) disable iff (!arst_n)
		saturated || last |-> out_valid)
		else $error("result flag outside a result beat");

	// a clipped result is one of the two range limits
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> out_value == SAT_MAX || out_value == SAT_MIN)
		else $error("saturated result not at a range limit");

endmodule

`default_nettype wire
